FILE: rtl/csvtok_pkg.sv
// shared types and constants of the csv field tokenizer
`default_nettype none

package csvtok_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] LF_BYTE     = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // results caused by one input word, entry 0 first
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RES-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic quoting;
    logic quote_pending;
    logic cr_pending;
    logic line_started;
  } tok_state_t;

endpackage

`default_nettype wire

FILE: rtl/csvtok_if.sv
// channel interfaces of the csv field tokenizer
`default_nettype none

interface csvtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface csvtok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_kind, out_byte, last_of_run, input ready);
  modport sink (input valid, out_kind, out_byte, last_of_run, output ready);
endinterface

interface csvtok_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] delimiter;

  modport source (output valid, delimiter, input ready);
  modport sink (input valid, delimiter, output ready);
endinterface

`default_nettype wire

FILE: rtl/csvtok_core.sv
// per-byte tokenizer rule: parse state and the results of one word
`default_nettype none

module csvtok_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_stream,
  input  logic [7:0]          delimiter,
  output csvtok_pkg::bundle_t bundle
);
  import csvtok_pkg::*;

  tok_state_t st_r;
  tok_state_t st_nxt;
  tok_state_t st_mid;
  bundle_t    bnd;
  logic [1:0] n;

  always_comb begin
    st_mid = st_r;
    bnd    = '0;
    n      = 2'd0;
    if (in_byte == LF_BYTE) begin
      if (st_mid.line_started) begin
        bnd.res[n] = '{kind: KIND_ROW, data: 8'h00};
        n = n + 2'd1;
      end
      st_mid = '0;
    end else begin
      if (st_mid.cr_pending) begin
        st_mid.cr_pending   = 1'b0;
        st_mid.line_started = 1'b1;
        bnd.res[n] = '{kind: KIND_DATA, data: CR_BYTE};
        n = n + 2'd1;
      end
      // pending quote closed by anything but another quote
      if (st_mid.quote_pending && in_byte != QUOTE_BYTE) begin
        st_mid.quote_pending = 1'b0;
        st_mid.quoting       = 1'b0;
      end
      if (in_byte == CR_BYTE) begin
        st_mid.cr_pending = 1'b1;
      end else if (in_byte == QUOTE_BYTE) begin
        st_mid.line_started = 1'b1;
        if (st_mid.quote_pending) begin
          st_mid.quote_pending = 1'b0;
          bnd.res[n] = '{kind: KIND_DATA, data: QUOTE_BYTE};
          n = n + 2'd1;
        end else if (st_mid.quoting) begin
          st_mid.quote_pending = 1'b1;
        end else begin
          st_mid.quoting = 1'b1;
        end
      end else if (in_byte == delimiter && !st_mid.quoting) begin
        st_mid.line_started = 1'b1;
        bnd.res[n] = '{kind: KIND_FIELD, data: 8'h00};
        n = n + 2'd1;
      end else begin
        st_mid.line_started = 1'b1;
        bnd.res[n] = '{kind: KIND_DATA, data: in_byte};
        n = n + 2'd1;
      end
    end
    // end of stream closes the line as an lf would
    if (end_of_stream) begin
      if (st_mid.line_started) begin
        bnd.res[n] = '{kind: KIND_ROW, data: 8'h00};
        n = n + 2'd1;
      end
      st_mid = '0;
    end
    bnd.cnt = n;
    st_nxt  = accept ? st_mid : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign bundle = bnd;

endmodule

`default_nettype wire

FILE: rtl/csv_field_tokenizer.sv
// top level of the csv field tokenizer: parse rule, result queue and config register
//
// in_ch carries one text byte per word plus an end_of_stream flag; out_ch
// carries one result per word: cell data byte, end of field, or end of field
// and row, with last_of_run high on the last result caused by an input word.
// cfg_ch writes the delimiter byte (comma after reset); it is always ready
// and must only be written while the block is idle.
// each accepted byte is parsed in the cycle it is taken; its zero to three
// results are registered as one group in a two-entry group queue and leave
// one per cycle while out_ch.ready is high, never in the cycle of acceptance.
// throughput: one input byte per cycle as long as bytes make at most one
// result each and out_ch is ready; a byte making k results holds the output
// for all k of them, the limit set by the single result port.
// bytes that make no result (cr, opening quote) never enter the queue.
// in_ch.ready is a registered "queue not full", so a stalled receiver holds
// at most two groups before input is back-pressured; nothing is lost.
// reset (rst_n low, synchronous) clears the parse state and the queue and
// sets the delimiter back to comma.
`default_nettype none

module csv_field_tokenizer (
  input  logic         clk,
  input  logic         rst_n,
  csvtok_in_if.sink    in_ch,
  csvtok_out_if.source out_ch,
  csvtok_cfg_if.sink   cfg_ch
);
  import csvtok_pkg::*;

  logic [7:0] delim_r;
  logic [7:0] delim_nxt;

  // group queue
  bundle_t    grp_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;

  bundle_t    new_grp;
  bundle_t    head;
  result_t    head_res;
  logic       in_acc;
  logic       push;
  logic       last;
  logic       pop;

  // configuration write port
  assign cfg_ch.ready = 1'b1;
  assign delim_nxt    = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.delimiter : delim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  // parse rule, state advances only on an accepted word
  assign in_ch.ready = (fill_r != 2'd2);
  assign in_acc      = in_ch.valid && in_ch.ready;

  csvtok_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .in_byte       (in_ch.in_byte),
    .end_of_stream (in_ch.end_of_stream),
    .delimiter     (delim_r),
    .bundle        (new_grp)
  );

  assign push = in_acc && (new_grp.cnt != 2'd0);

  // head group drains one result per word
  assign head     = grp_r[rd_ptr_r];
  assign head_res = head.res[idx_r];
  assign last     = (idx_r == head.cnt - 2'd1);
  assign pop      = out_ch.valid && out_ch.ready && last;

  assign out_ch.valid       = (fill_r != 2'd0);
  assign out_ch.out_kind    = head_res.kind;
  assign out_ch.out_byte    = head_res.data;
  assign out_ch.last_of_run = last;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
    idx_nxt    = idx_r;
    if (out_ch.valid && out_ch.ready) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // group storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      grp_r[wr_ptr_r] <= new_grp;
    end
  end

endmodule

`default_nettype wire
